@@ src/p2f_pkg.sv @@
// ----------------------------------------------------------------------------
// p2f_pkg
// Shared types and constants for the posit-to-float32 converter.
// ----------------------------------------------------------------------------
package p2f_pkg;

	localparam int DEF_POSIT_WIDTH = 16;
	localparam int POSIT_PORT_W    = 16;

	localparam int          EXP_W           = 8;
	localparam int          FLOAT_FRAC_BITS = 23;
	localparam logic [7:0]  FLOAT_BIAS      = 8'((1 << (EXP_W - 1)) - 1);
	localparam logic [7:0]  FLOAT_EXP_MASK  = 8'hFF;
	localparam logic [31:0] FLOAT_QNAN      = 32'h7FC0_0000;
	localparam logic [31:0] FLOAT_POS_ZERO  = 32'h0000_0000;

	localparam int         ES_W     = 2;
	localparam int         EXPV_W   = 3;
	localparam logic [1:0] ES_RESET = 2'd2;

	// APB register map
	localparam int         PADDR_W    = 3;
	localparam int         PDATA_W    = 32;
	localparam logic [0:0] REG_ES_IDX = 1'b0;

	// control that travels with each request through the pipe
	typedef struct packed {
		logic            valid;
		logic            sign;
		logic            zero;
		logic            nar;
		logic [ES_W-1:0] es;
	} p2f_ctrl_t;

endpackage

@@ src/p2f_regs.sv @@
// ----------------------------------------------------------------------------
// p2f_regs
// APB register block: holds the exponent_size setting.
// ----------------------------------------------------------------------------
module p2f_regs
	import p2f_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [ES_W-1:0]    exponent_size
);

	logic [ES_W-1:0] es_q;
	logic            hit_es;

	assign hit_es = (paddr[PADDR_W-1:2] == REG_ES_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q <= ES_RESET;
		end else if (psel && penable && pwrite && hit_es) begin
			es_q <= pwdata[ES_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit_es) begin
			prdata = {{(PDATA_W-ES_W){1'b0}}, es_q};
		end
	end

	assign pready        = 1'b1;
	assign exponent_size = es_q;

endmodule

@@ src/p2f_decode.sv @@
// ----------------------------------------------------------------------------
// p2f_decode
// Stages 1-2: magnitude of the posit body, then regime run length and value.
// ----------------------------------------------------------------------------
module p2f_decode
	import p2f_pkg::*;
#(
	parameter int POSIT_WIDTH = DEF_POSIT_WIDTH,
	localparam int RUN_W = $clog2(POSIT_WIDTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [POSIT_PORT_W-1:0] posit_bits,
	input  logic [ES_W-1:0]         es,
	output p2f_ctrl_t               ctrl_s2,
	output logic [POSIT_WIDTH-2:0]  mag_s2,
	output logic [RUN_W-1:0]        run_s2,
	output logic [EXP_W-1:0]        regime_s2
);

	localparam int BW = POSIT_WIDTH - 1;

	logic [BW-1:0] body;
	logic [BW-1:0] neg_body;
	logic          sign;
	logic          body_zero;
	p2f_ctrl_t     ctrl_d;
	p2f_ctrl_t     ctrl_s1;
	logic [BW-1:0] mag_s1;

	logic             lead;
	logic [BW-1:0]    diff;
	logic [RUN_W-1:0] run;
	logic [EXP_W-1:0] run_x;
	logic [EXP_W-1:0] regime;

	// stage 1: sign split and two's complement
	assign sign      = posit_bits[POSIT_WIDTH-1];
	assign body      = posit_bits[BW-1:0];
	assign body_zero = (body == '0);
	assign neg_body  = ~body + {{(BW-1){1'b0}}, 1'b1};

	always_comb begin
		ctrl_d       = '0;
		ctrl_d.valid = in_valid;
		ctrl_d.sign  = sign;
		ctrl_d.zero  = body_zero && !sign;
		ctrl_d.nar   = body_zero && sign;
		ctrl_d.es    = es;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= sign ? neg_body : body;
	end

	// stage 2: leading run of identical bits below the sign
	assign lead = mag_s1[BW-1];
	assign diff = mag_s1 ^ {BW{lead}};

	always_comb begin
		run = RUN_W'(BW);
		for (int i = 0; i < BW; i++) begin
			if (diff[i]) begin
				run = RUN_W'(BW - 1 - i);
			end
		end
	end

	assign run_x  = EXP_W'(run);
	assign regime = lead ? (run_x - 8'd1) : (8'd0 - run_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s2    <= mag_s1;
		run_s2    <= run;
		regime_s2 <= regime;
	end

endmodule

@@ src/p2f_align.sv @@
// ----------------------------------------------------------------------------
// p2f_align
// Stage 3: strip regime, extract exponent bits, form biased exponent.
// ----------------------------------------------------------------------------
module p2f_align
	import p2f_pkg::*;
#(
	parameter int POSIT_WIDTH = DEF_POSIT_WIDTH,
	localparam int RUN_W = $clog2(POSIT_WIDTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  p2f_ctrl_t              ctrl_s2,
	input  logic [POSIT_WIDTH-2:0] mag_s2,
	input  logic [RUN_W-1:0]       run_s2,
	input  logic [EXP_W-1:0]       regime_s2,
	output p2f_ctrl_t              ctrl_s3,
	output logic [EXP_W-1:0]       biased_s3,
	output logic [POSIT_WIDTH-2:0] frac_s3
);

	localparam int BW = POSIT_WIDTH - 1;

	logic [RUN_W:0]    shamt;
	logic [BW-1:0]     aligned;
	logic [EXPV_W-1:0] exp_val;
	logic [EXP_W-1:0]  scaled;

	// drop regime and terminator; missing tail bits shift in as zero
	assign shamt   = {1'b0, run_s2} + {{RUN_W{1'b0}}, 1'b1};
	assign aligned = mag_s2 << shamt;

	always_comb begin
		case (ctrl_s2.es)
			2'd0:    exp_val = '0;
			2'd1:    exp_val = {2'b00, aligned[BW-1]};
			2'd2:    exp_val = {1'b0, aligned[BW-1 -: 2]};
			2'd3:    exp_val = aligned[BW-1 -: 3];
			default: exp_val = '0;
		endcase
	end

	assign scaled = regime_s2 << ctrl_s2.es;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		biased_s3 <= (scaled + {{(EXP_W-EXPV_W){1'b0}}, exp_val} + FLOAT_BIAS) & FLOAT_EXP_MASK;
		frac_s3   <= aligned << ctrl_s2.es;
	end

endmodule

@@ src/p2f_pack.sv @@
// ----------------------------------------------------------------------------
// p2f_pack
// Stage 4: assemble the single-precision word, special values override.
// ----------------------------------------------------------------------------
module p2f_pack
	import p2f_pkg::*;
#(
	parameter int POSIT_WIDTH = DEF_POSIT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  p2f_ctrl_t              ctrl_s3,
	input  logic [EXP_W-1:0]       biased_s3,
	input  logic [POSIT_WIDTH-2:0] frac_s3,
	output logic                   done,
	output logic [31:0]            float_bits
);

	localparam int PAD_W = FLOAT_FRAC_BITS - (POSIT_WIDTH - 1);

	logic        valid_s4;
	logic [31:0] float_s4;
	logic [31:0] word;

	always_comb begin
		if (ctrl_s3.nar) begin
			word = FLOAT_QNAN;
		end else if (ctrl_s3.zero) begin
			word = FLOAT_POS_ZERO;
		end else begin
			word = {ctrl_s3.sign, biased_s3, frac_s3, {PAD_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= ctrl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		float_s4 <= word;
	end

	assign done       = valid_s4;
	assign float_bits = float_s4;

endmodule

@@ src/posit_to_float32_converter_top.sv @@
// ----------------------------------------------------------------------------
// posit_to_float32_converter_top
// Posit (POSIT_WIDTH bits, programmable exponent size) to IEEE single.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction  timing
//  request   start, busy, posit_bits                 in         1 per cycle
//  result    done, float_bits                        out        from stage 4
//  config    psel penable pwrite paddr pwdata        in         APB, no wait
//            prdata pready                           out
//
//  Four register stages: magnitude, regime run, alignment, packing.
//  One request per cycle; busy is tied low.
//  Reset clears the stage valid bits and sets exponent_size to 2.
//  The result strobe cannot be held off, so there is no stall path.
//  exponent_size is captured with each request on entry.
// ----------------------------------------------------------------------------
module posit_to_float32_converter_top
	import p2f_pkg::*;
#(
	parameter int POSIT_WIDTH = DEF_POSIT_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [POSIT_PORT_W-1:0] posit_bits,
	output logic                    done,
	output logic [31:0]             float_bits,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	localparam int RUN_W = $clog2(POSIT_WIDTH);

	logic [ES_W-1:0]        exponent_size;
	p2f_ctrl_t              ctrl_s2;
	p2f_ctrl_t              ctrl_s3;
	logic [POSIT_WIDTH-2:0] mag_s2;
	logic [RUN_W-1:0]       run_s2;
	logic [EXP_W-1:0]       regime_s2;
	logic [EXP_W-1:0]       biased_s3;
	logic [POSIT_WIDTH-2:0] frac_s3;

	assign busy = 1'b0;

	p2f_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.exponent_size (exponent_size)
	);

	p2f_decode #(.POSIT_WIDTH(POSIT_WIDTH)) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.posit_bits (posit_bits),
		.es         (exponent_size),
		.ctrl_s2    (ctrl_s2),
		.mag_s2     (mag_s2),
		.run_s2     (run_s2),
		.regime_s2  (regime_s2)
	);

	p2f_align #(.POSIT_WIDTH(POSIT_WIDTH)) u_align (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s2   (ctrl_s2),
		.mag_s2    (mag_s2),
		.run_s2    (run_s2),
		.regime_s2 (regime_s2),
		.ctrl_s3   (ctrl_s3),
		.biased_s3 (biased_s3),
		.frac_s3   (frac_s3)
	);

	p2f_pack #(.POSIT_WIDTH(POSIT_WIDTH)) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_s3    (ctrl_s3),
		.biased_s3  (biased_s3),
		.frac_s3    (frac_s3),
		.done       (done),
		.float_bits (float_bits)
	);

	// every accepted request comes out with a done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("request did not complete in four cycles");

	// posit zero maps to +0
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && posit_bits[POSIT_WIDTH-1:0] == '0)
		|-> ##4 (done && float_bits == FLOAT_POS_ZERO))
		else $error("posit zero did not give +0");

	// only NaR may produce an all-ones exponent field
	a_no_inf: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (float_bits[30:23] != FLOAT_EXP_MASK || float_bits == FLOAT_QNAN))
		else $error("exponent overflow on a finite posit");

endmodule

@@ test/posit_to_float32_converter_top_tb.sv @@
// ----------------------------------------------------------------------------
// posit_to_float32_converter_top_tb
// Drives posit words into the converter and checks every float32 result
// against the table value where given, else an in-bench model. A directed
// table covers the extremes, zero, NaR and truncated exponents at several
// exponent sizes, then random words under three request idle patterns.
// ----------------------------------------------------------------------------
module posit_to_float32_converter_top_tb
	import p2f_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY     = 4;
	localparam int MAX_REPORTS = 20;
	localparam int N_VECTORS   = 26;
	localparam int N_SEGMENTS  = 4;
	localparam int SEG_ITEMS   = 84;

	localparam logic [PADDR_W-1:0] ADDR_ES     = PADDR_W'(4 * REG_ES_IDX);
	localparam logic [PADDR_W-1:0] ADDR_UNUSED = PADDR_W'(4);

	typedef struct packed {
		logic [ES_W-1:0]         es;
		logic [POSIT_PORT_W-1:0] word;
		logic                    known;
		logic [31:0]             float_val;
	} vector_t;

	// typed results are read straight off the posit definition (es = 2)
	localparam vector_t VECTORS [0:N_VECTORS-1] = '{
		'{2'd2, 16'h0000, 1'b1, FLOAT_POS_ZERO},
		'{2'd2, 16'h8000, 1'b1, FLOAT_QNAN},
		'{2'd2, 16'h4000, 1'b1, 32'h3F80_0000},
		'{2'd2, 16'hC000, 1'b1, 32'hBF80_0000},
		'{2'd2, 16'h7FFF, 1'b1, 32'h5B80_0000},
		'{2'd2, 16'h0001, 1'b1, 32'h2380_0000},
		'{2'd2, 16'h8001, 1'b1, 32'hDB80_0000},
		'{2'd2, 16'hFFFF, 1'b1, 32'hA380_0000},
		'{2'd2, 16'h7FFD, 1'b0, 32'h0},
		'{2'd2, 16'h7FFE, 1'b0, 32'h0},
		'{2'd2, 16'h0003, 1'b0, 32'h0},
		'{2'd2, 16'h5A5A, 1'b0, 32'h0},
		'{2'd2, 16'h2B3C, 1'b0, 32'h0},
		'{2'd2, 16'h9C3F, 1'b0, 32'h0},
		'{2'd0, 16'h7FFF, 1'b0, 32'h0},
		'{2'd0, 16'h0001, 1'b0, 32'h0},
		'{2'd0, 16'h4001, 1'b0, 32'h0},
		'{2'd0, 16'hB7A5, 1'b0, 32'h0},
		'{2'd0, 16'h6AAA, 1'b0, 32'h0},
		'{2'd3, 16'h7FFF, 1'b0, 32'h0},
		'{2'd3, 16'h0001, 1'b0, 32'h0},
		'{2'd3, 16'h7FFD, 1'b0, 32'h0},
		'{2'd3, 16'h3FFF, 1'b0, 32'h0},
		'{2'd3, 16'hE123, 1'b0, 32'h0},
		'{2'd1, 16'h4000, 1'b0, 32'h0},
		'{2'd1, 16'h1357, 1'b0, 32'h0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [POSIT_PORT_W-1:0] posit_bits;
	logic                    done;
	logic [31:0]             float_bits;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [PADDR_W-1:0]      paddr;
	logic [PDATA_W-1:0]      pwdata;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;

	logic [31:0]     float_expected [$];
	logic [ES_W-1:0] cur_es;
	logic [31:0]     want_float;
	int              err_count;
	int              idle_pct;

	posit_to_float32_converter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.posit_bits (posit_bits),
		.done       (done),
		.float_bits (float_bits),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500_000;
		$display("[posit_to_float32_converter_top] ERROR");
		$finish;
	end

	function automatic logic [31:0] posit_to_float(input logic [POSIT_PORT_W-1:0] word,
		input logic [ES_W-1:0] es);
		logic [DEF_POSIT_WIDTH-1:0] w, body_mask, body, mag;
		logic                       sgn, lead;
		int                         pos, run, rem, es_i, avail, flen, regime, biased;
		logic [31:0]                exp_val, frac;
		logic [7:0]                 exp_field;
		w = word[DEF_POSIT_WIDTH-1:0];
		body_mask = {1'b0, {(DEF_POSIT_WIDTH-1){1'b1}}};
		sgn = w[DEF_POSIT_WIDTH-1];
		body = w & body_mask;
		if (body == '0)
			return sgn ? FLOAT_QNAN : FLOAT_POS_ZERO;
		mag = sgn ? ((~body + 1'b1) & body_mask) : body;
		lead = mag[DEF_POSIT_WIDTH-2];
		run = 0;
		pos = DEF_POSIT_WIDTH - 2;
		while (pos >= 0 && mag[pos] == lead) begin
			run++;
			pos--;
		end
		regime = lead ? run - 1 : -run;
		rem = DEF_POSIT_WIDTH - 2 - run;
		if (rem < 0)
			rem = 0;
		es_i = int'(es);
		avail = (rem < es_i) ? rem : es_i;
		exp_val = '0;
		if (avail > 0)
			exp_val = (32'(mag) >> (rem - avail)) & ((32'd1 << avail) - 32'd1);
		// missing exponent bits past the end of the word read as zero
		exp_val = exp_val << (es_i - avail);
		flen = rem - es_i;
		if (flen < 0)
			flen = 0;
		frac = (32'(mag) & ((32'd1 << flen) - 32'd1)) << (FLOAT_FRAC_BITS - flen);
		biased = regime * (1 << es_i) + int'(exp_val) + int'(FLOAT_BIAS);
		exp_field = 8'(biased) & FLOAT_EXP_MASK;
		return {sgn, exp_field, frac[FLOAT_FRAC_BITS-1:0]};
	endfunction

	function automatic logic [POSIT_PORT_W-1:0] random_posit();
		logic [POSIT_PORT_W-1:0] w;
		logic                    lead;
		int                      run, i, pick;
		w = POSIT_PORT_W'($urandom);
		pick = $urandom_range(9);
		if (pick == 0) begin
			case ($urandom_range(3))
				0: w = 16'h0000;
				1: w = 16'h8000;
				2: w = 16'h7FFF;
				default: w = 16'h0001;
			endcase
		end else if (pick >= 5) begin
			// force a chosen regime run length, rest random
			lead = 1'($urandom);
			run = $urandom_range(1, DEF_POSIT_WIDTH - 1);
			for (i = 0; i < run; i++)
				w[DEF_POSIT_WIDTH-2-i] = lead;
			if (run < DEF_POSIT_WIDTH - 1)
				w[DEF_POSIT_WIDTH-2-run] = ~lead;
		end
		return w;
	endfunction

	task automatic send_posit(input logic [POSIT_PORT_W-1:0] word, input logic [31:0] want);
		@(negedge clk);
		start <= 1'b1;
		posit_bits <= word;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		float_expected.push_back(want);
	endtask

	// each pass idles the request side, so idle_pct is the share of idle cycles
	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (float_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_ES)
			cur_es = data[ES_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_exp_size(input logic [ES_W-1:0] es);
		wait_idle();
		apb_write(ADDR_ES, {30'($urandom), es});
	endtask

	// result checker: one expectation per done strobe, oldest first
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (float_expected.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: result with no request pending, got %h", $time, float_bits);
			end else begin
				want_float = float_expected.pop_front();
				if (float_bits !== want_float) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: float_bits mismatch, expected %h got %h",
							$time, want_float, float_bits);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		posit_bits = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_es = ES_RESET;
		err_count = 0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// write to a register index that does not exist: must leave es alone
		apb_write(ADDR_UNUSED, 32'h0000_0001);

		foreach (VECTORS[i]) begin
			if (VECTORS[i].es != cur_es)
				set_exp_size(VECTORS[i].es);
			send_posit(VECTORS[i].word, VECTORS[i].known ? VECTORS[i].float_val :
				posit_to_float(VECTORS[i].word, cur_es));
		end

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 10 : (phase == 1) ? 67 : 0;
			for (int seg = 0; seg < N_SEGMENTS; seg++) begin
				set_exp_size(ES_W'($urandom_range(3)));
				for (int k = 0; k < SEG_ITEMS; k++) begin
					logic [POSIT_PORT_W-1:0] w;
					w = random_posit();
					send_posit(w, posit_to_float(w, cur_es));
					idle_gap();
				end
			end
		end

		wait_idle();
		if (err_count == 0 && float_expected.size() == 0) begin
			$display("[posit_to_float32_converter_top] OK");
		end else begin
			$display("[posit_to_float32_converter_top] ERROR");
		end
		$finish;
	end

endmodule
